// ----- hdl/sie_pkg.sv -----
// sie_pkg: opcodes, condition codes and controller/datapath command types
// for the SIC instruction execute core. No dependencies.
`default_nettype none
package sie_pkg;

  localparam int WORD_BITS = 24;

  typedef enum logic [7:0] {
    OP_LDA  = 8'h00, OP_LDCH = 8'h50, OP_LDL  = 8'h08, OP_LDX  = 8'h04,
    OP_STA  = 8'h0C, OP_STCH = 8'h54, OP_STL  = 8'h14, OP_STX  = 8'h10,
    OP_ADD  = 8'h18, OP_SUB  = 8'h1C, OP_MUL  = 8'h20, OP_DIV  = 8'h24,
    OP_AND  = 8'h40, OP_OR   = 8'h44, OP_COMP = 8'h28, OP_TIX  = 8'h2C,
    OP_J    = 8'h3C, OP_JEQ  = 8'h30, OP_JGT  = 8'h34, OP_JLT  = 8'h38,
    OP_JSUB = 8'h48, OP_RSUB = 8'h4C, OP_HLT  = 8'hFF
  } opcode_t;

  localparam logic [1:0] CC_EQ = 2'd0;
  localparam logic [1:0] CC_LT = 2'd1;
  localparam logic [1:0] CC_GT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic exec;      // execute an instruction other than a nonzero div
    logic div_start; // begin the divide iteration
    logic div_step;  // one quotient bit
    logic div_done;  // write the quotient
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;    // captured opcode is a div with nonzero divisor
    logic div_last;  // final quotient bit in progress
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- hdl/sic_instruction_execute_core.sv -----
// SIC instruction execute core: one instruction per transfer.
// out_valid rises after the item is registered and decoded; a nonzero div runs
// decode, divider setup, 24 quotient bits from the restoring divider, then write.
// A new item is taken only once the previous one has been written; a result
// still stalled at the output holds the next instruction before its write.
// Reset (synchronous, rst_n low) clears A, X, L, PC, condition code and control.
`default_nettype none
module sic_instruction_execute_core #(
  parameter int ADDRESS_BITS = 15
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_command,
  input  wire logic [ADDRESS_BITS-1:0] in_target_address,
  input  wire logic [23:0]             in_operand_word,
  input  wire logic [ADDRESS_BITS-1:0] in_fall_through_address,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [23:0]           out_accumulator,
  output logic signed [23:0]           out_index_reg,
  output logic [23:0]                  out_link_reg,
  output logic [ADDRESS_BITS-1:0]      out_next_pc,
  output logic [1:0]                   out_cond_code,
  output logic                         out_store_valid,
  output logic                         out_store_byte_only,
  output logic [ADDRESS_BITS-1:0]      out_store_address,
  output logic [23:0]                  out_store_data,
  output logic                         out_halted,
  output logic                         out_divide_by_zero,
  output logic                         out_illegal_opcode
);

  sie_pkg::ctrl_cmd_t cmd;
  sie_pkg::ctrl_sts_t sts;

  sie_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  sie_dp #(.ADDRESS_BITS(ADDRESS_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_command, .in_target_address, .in_operand_word, .in_fall_through_address,
    .out_accumulator, .out_index_reg, .out_link_reg, .out_next_pc, .out_cond_code,
    .out_store_valid, .out_store_byte_only, .out_store_address, .out_store_data,
    .out_halted, .out_divide_by_zero, .out_illegal_opcode
  );

endmodule
`default_nettype wire

// ----- hdl/sie_ctrl.sv -----
// sie_ctrl: controller state machine for the SIC execute core.
// Depends on sie_pkg.
`default_nettype none
module sie_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sie_pkg::ctrl_cmd_t      cmd,
  input  wire sie_pkg::ctrl_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DIV_INIT, S_DIV, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // accept while idle; the output register may still be waiting
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_div) begin
          state_nxt = S_DIV_INIT;
        end else if (!out_valid_r || !out_stall) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.div_done  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sie_dp.sv -----
// sie_dp: register file, ALU, restoring divider and result register
// of the SIC execute core. Depends on sie_pkg.
`default_nettype none
module sie_dp #(
  parameter int ADDRESS_BITS = 15
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sie_pkg::ctrl_cmd_t       cmd,
  output sie_pkg::ctrl_sts_t            sts,
  input  wire logic [7:0]               in_command,
  input  wire logic [ADDRESS_BITS-1:0]  in_target_address,
  input  wire logic [23:0]              in_operand_word,
  input  wire logic [ADDRESS_BITS-1:0]  in_fall_through_address,
  output logic signed [23:0]            out_accumulator,
  output logic signed [23:0]            out_index_reg,
  output logic [23:0]                   out_link_reg,
  output logic [ADDRESS_BITS-1:0]       out_next_pc,
  output logic [1:0]                    out_cond_code,
  output logic                          out_store_valid,
  output logic                          out_store_byte_only,
  output logic [ADDRESS_BITS-1:0]       out_store_address,
  output logic [23:0]                   out_store_data,
  output logic                          out_halted,
  output logic                          out_divide_by_zero,
  output logic                          out_illegal_opcode
);

  localparam int W = sie_pkg::WORD_BITS;

  // captured item
  logic [7:0]              op_r;
  logic [ADDRESS_BITS-1:0] addr_r, fall_r;
  logic [W-1:0]            word_r;

  // architectural state
  logic [W-1:0]            a_r, x_r, l_r, a_nxt, x_nxt, l_nxt;
  logic [1:0]              cc_r, cc_nxt;
  logic [ADDRESS_BITS-1:0] pc_r, pc_nxt;

  // divider
  logic [W-1:0]            dq_r, dd_r;
  logic [W:0]              rem_r;
  logic [4:0]              dcnt_r;
  logic                    dneg_r;
  logic [W:0]              trial;
  logic [W-1:0]            quot;

  // result register fields
  logic st_v, st_b, hlt, dz, ill;
  logic [W-1:0] st_d;
  logic [W-1:0] prod;
  logic [W-1:0] tix_x;

  function automatic logic [1:0] cmp_code(input logic [W-1:0] l, input logic [W-1:0] r);
    if (l == r) return sie_pkg::CC_EQ;
    return ($signed(l) < $signed(r)) ? sie_pkg::CC_LT : sie_pkg::CC_GT;
  endfunction

  assign sts.is_div   = (op_r == sie_pkg::OP_DIV) && (word_r != '0);
  assign sts.div_last = (dcnt_r == 5'd1);

  // low word of the product is the same for signed and unsigned operands
  assign prod  = a_r * word_r;
  assign tix_x = x_r + 1'b1;
  assign trial = {rem_r[W-1:0], dq_r[W-1]} - {1'b0, dd_r};
  assign quot  = dneg_r ? (~dq_r + 1'b1) : dq_r;

  always_comb begin
    a_nxt  = a_r;
    x_nxt  = x_r;
    l_nxt  = l_r;
    cc_nxt = cc_r;
    pc_nxt = fall_r;
    st_v = 1'b0; st_b = 1'b0; st_d = '0; hlt = 1'b0; dz = 1'b0; ill = 1'b0;
    unique case (op_r)
      sie_pkg::OP_LDA:  a_nxt = word_r;
      sie_pkg::OP_LDCH: a_nxt = {a_r[W-1:8], word_r[W-1:W-8]};
      sie_pkg::OP_LDL:  l_nxt = word_r;
      sie_pkg::OP_LDX:  x_nxt = word_r;
      sie_pkg::OP_STA:  begin st_v = 1'b1; st_d = a_r; end
      sie_pkg::OP_STCH: begin st_v = 1'b1; st_b = 1'b1; st_d = {16'd0, a_r[7:0]}; end
      sie_pkg::OP_STL:  begin st_v = 1'b1; st_d = l_r; end
      sie_pkg::OP_STX:  begin st_v = 1'b1; st_d = x_r; end
      sie_pkg::OP_ADD:  a_nxt = a_r + word_r;
      sie_pkg::OP_SUB:  a_nxt = a_r - word_r;
      sie_pkg::OP_MUL:  a_nxt = prod;
      sie_pkg::OP_DIV: begin
        if (word_r == '0) dz = 1'b1;
        else a_nxt = quot;
      end
      sie_pkg::OP_AND:  a_nxt = a_r & word_r;
      sie_pkg::OP_OR:   a_nxt = a_r | word_r;
      sie_pkg::OP_COMP: cc_nxt = cmp_code(a_r, word_r);
      sie_pkg::OP_TIX: begin
        x_nxt  = tix_x;
        cc_nxt = cmp_code(tix_x, word_r);
      end
      sie_pkg::OP_J:    pc_nxt = addr_r;
      sie_pkg::OP_JEQ:  if (cc_r == sie_pkg::CC_EQ) pc_nxt = addr_r;
      sie_pkg::OP_JGT:  if (cc_r == sie_pkg::CC_GT) pc_nxt = addr_r;
      sie_pkg::OP_JLT:  if (cc_r == sie_pkg::CC_LT) pc_nxt = addr_r;
      sie_pkg::OP_JSUB: begin l_nxt = W'(fall_r); pc_nxt = addr_r; end
      sie_pkg::OP_RSUB: pc_nxt = l_r[ADDRESS_BITS-1:0];
      sie_pkg::OP_HLT:  hlt = 1'b1;
      default:          ill = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_command;
      addr_r <= in_target_address;
      word_r <= in_operand_word;
      fall_r <= in_fall_through_address;
    end
    // magnitudes; quotient shifts in where dividend bits leave
    if (cmd.div_start) begin
      dq_r   <= a_r[W-1] ? (~a_r + 1'b1) : a_r;
      dd_r   <= word_r[W-1] ? (~word_r + 1'b1) : word_r;
      dneg_r <= a_r[W-1] ^ word_r[W-1];
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      if (!trial[W]) rem_r <= trial;
      else           rem_r <= {rem_r[W-1:0], dq_r[W-1]};
      dq_r <= {dq_r[W-2:0], ~trial[W]};
    end
    if (cmd.exec || cmd.div_done) begin
      out_store_valid     <= st_v;
      out_store_byte_only <= st_b;
      out_store_address   <= st_v ? addr_r : '0;
      out_store_data      <= st_d;
      out_halted          <= hlt;
      out_divide_by_zero  <= dz;
      out_illegal_opcode  <= ill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; x_r <= '0; l_r <= '0; cc_r <= sie_pkg::CC_EQ; pc_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.div_start) dcnt_r <= 5'(W);
      else if (cmd.div_step) dcnt_r <= dcnt_r - 1'b1;
      if (cmd.exec || cmd.div_done) begin
        a_r <= a_nxt; x_r <= x_nxt; l_r <= l_nxt; cc_r <= cc_nxt; pc_r <= pc_nxt;
      end
    end
  end

  assign out_accumulator = a_r;
  assign out_index_reg   = x_r;
  assign out_link_reg    = l_r;
  assign out_next_pc     = pc_r;
  assign out_cond_code   = cc_r;

endmodule
`default_nettype wire

// ----- hdl/sie_checker.sv -----
// sie_checker: port-level properties of the SIC execute core, and its bind.
// Depends on sic_instruction_execute_core ports only.
`default_nettype none
module sie_checker #(
  parameter int ADDRESS_BITS = 15
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [1:0]              out_cond_code,
  input wire logic                    out_store_valid,
  input wire logic [ADDRESS_BITS-1:0] out_store_address,
  input wire logic                    out_halted,
  input wire logic                    out_divide_by_zero,
  input wire logic                    out_illegal_opcode
);

  a_cc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cond_code != 2'd3) else $error("bad condition code");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_store_valid, out_halted, out_divide_by_zero,
                            out_illegal_opcode})) else $error("flags overlap");

  a_store_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_store_valid) |-> out_store_address == '0)
    else $error("store address without store");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid ##1 out_valid) |-> $past(in_stall)) else $error("spurious result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

bind sic_instruction_execute_core sie_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_sie_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_cond_code,
  .out_store_valid, .out_store_address, .out_halted, .out_divide_by_zero,
  .out_illegal_opcode
);
`default_nettype wire
